>>> design/nfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfs_pkg
// Shared types and constants for the NEC infrared frame sequencer.
// ----------------------------------------------------------------------------
package nfs_pkg;

    // Fixed segment lengths in timer ticks.
    localparam logic [15:0] LEAD_IN_TICKS      = 16'd1000;
    localparam logic [15:0] REPEAT_SPACE_TICKS = 16'd2250;
    localparam logic [7:0]  BYTE_MASK          = 8'hFF;

    // Register reset values.
    localparam logic [15:0] RST_CUSTOMER_CODE = 16'd65280;
    localparam logic        RST_MARK_MODE     = 1'b0;
    localparam logic [15:0] RST_LEADER_MARK   = 16'd9000;
    localparam logic [15:0] RST_LEADER_SPACE  = 16'd4500;
    localparam logic [15:0] RST_BIT_MARK      = 16'd560;
    localparam logic [15:0] RST_ONE_SPACE     = 16'd1690;
    localparam logic [15:0] RST_ZERO_SPACE    = 16'd560;
    localparam logic [15:0] RST_FRAME_GAP     = 16'd41000;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CUSTOMER_CODE = 3'd0;
    localparam logic [2:0] CFG_MARK_MODE     = 3'd1;
    localparam logic [2:0] CFG_LEADER_MARK   = 3'd2;
    localparam logic [2:0] CFG_LEADER_SPACE  = 3'd3;
    localparam logic [2:0] CFG_BIT_MARK      = 3'd4;
    localparam logic [2:0] CFG_ONE_SPACE     = 3'd5;
    localparam logic [2:0] CFG_ZERO_SPACE    = 3'd6;
    localparam logic [2:0] CFG_FRAME_GAP     = 3'd7;

    // Request modes.
    localparam logic MODE_START    = 1'b0;
    localparam logic MODE_SEG_DONE = 1'b1;

    // Line drive kinds.
    localparam logic [1:0] DRV_IDLE    = 2'd0;
    localparam logic [1:0] DRV_CARRIER = 2'd1;
    localparam logic [1:0] DRV_LOW     = 2'd2;

    // Byte selects within the 32 data bits.
    localparam logic [1:0] SEL_ID      = 2'd0;
    localparam logic [1:0] SEL_ID_INV  = 2'd1;
    localparam logic [1:0] SEL_CMD     = 2'd2;
    localparam logic [1:0] SEL_CMD_INV = 2'd3;
    localparam logic [2:0] LAST_BIT    = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_LEADIN = 4'd1,
        PH_LMARK  = 4'd2,
        PH_LSPACE = 4'd3,
        PH_DATA   = 4'd4,
        PH_STOP   = 4'd5,
        PH_GAP    = 4'd6,
        PH_RMARK  = 4'd7,
        PH_RSPACE = 4'd8,
        PH_RSTOP  = 4'd9
    } t_phase;

    typedef struct packed {
        logic [15:0] customer_code;
        logic        mark_mode;
        logic [15:0] leader_mark;
        logic [15:0] leader_space;
        logic [15:0] bit_mark;
        logic [15:0] one_space;
        logic [15:0] zero_space;
        logic [15:0] frame_gap;
    } t_cfg;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] bit_index;
        logic       in_space;
        logic [1:0] byte_select;
        logic [7:0] command_byte;
    } t_state;

    typedef struct packed {
        logic [1:0]  drive;
        logic [15:0] duration;
        logic        frame_done;
    } t_seg;

endpackage
`default_nettype wire

>>> design/nfs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfs_step
// Next-state and segment logic: from the current sequencer state, the
// registers and one request, works out the new state and the segment to emit.
// ----------------------------------------------------------------------------
module nfs_step (
    input  wire nfs_pkg::t_state i_state,
    input  wire nfs_pkg::t_cfg   i_cfg,
    input  wire                  i_mode,
    input  wire [7:0]            i_command,
    output nfs_pkg::t_state      o_state,
    output logic                 o_emit,
    output nfs_pkg::t_seg        o_seg
);

    logic       busy;
    logic [1:0] mark_drv;
    logic [7:0] data_byte;
    logic       data_bit;

    // The frame is in progress in any defined phase other than idle.
    always_comb begin
        busy = (i_state.phase inside {[nfs_pkg::PH_LEADIN : nfs_pkg::PH_RSTOP]});
        mark_drv = i_cfg.mark_mode ? nfs_pkg::DRV_LOW : nfs_pkg::DRV_CARRIER;
    end

    // Byte currently being sent, and the bit of it picked by the bit index.
    always_comb begin
        case (i_state.byte_select)
            nfs_pkg::SEL_ID:     data_byte = i_cfg.customer_code[7:0];
            nfs_pkg::SEL_ID_INV: data_byte = i_cfg.customer_code[15:8];
            nfs_pkg::SEL_CMD:    data_byte = i_state.command_byte;
            default:             data_byte = i_state.command_byte ^ nfs_pkg::BYTE_MASK;
        endcase
        data_bit = data_byte[i_state.bit_index];
    end

    // Phase sequencing and segment selection.
    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        o_seg   = '{drive: nfs_pkg::DRV_IDLE, duration: 16'd0, frame_done: 1'b0};

        if (!busy) begin
            o_state.phase = nfs_pkg::PH_IDLE;
        end

        if (i_mode == nfs_pkg::MODE_START) begin
            // A start while busy is dropped; otherwise it opens a frame.
            if (!busy) begin
                o_state.command_byte = i_command;
                o_state.bit_index    = 3'd0;
                o_state.byte_select  = nfs_pkg::SEL_ID;
                o_state.in_space     = 1'b0;
                o_state.phase        = nfs_pkg::PH_LEADIN;
                o_emit               = 1'b1;
                o_seg.duration       = nfs_pkg::LEAD_IN_TICKS;
            end
        end else begin
            case (i_state.phase)
                nfs_pkg::PH_LEADIN: begin
                    o_state.phase  = nfs_pkg::PH_LMARK;
                    o_emit         = 1'b1;
                    o_seg.drive    = mark_drv;
                    o_seg.duration = i_cfg.leader_mark;
                end
                nfs_pkg::PH_LMARK: begin
                    o_state.phase  = nfs_pkg::PH_LSPACE;
                    o_emit         = 1'b1;
                    o_seg.duration = i_cfg.leader_space;
                end
                nfs_pkg::PH_LSPACE: begin
                    o_state.phase       = nfs_pkg::PH_DATA;
                    o_state.bit_index   = 3'd0;
                    o_state.byte_select = nfs_pkg::SEL_ID;
                    o_state.in_space    = 1'b0;
                    o_emit              = 1'b1;
                    o_seg.drive         = mark_drv;
                    o_seg.duration      = i_cfg.bit_mark;
                end
                nfs_pkg::PH_DATA: begin
                    o_emit = 1'b1;
                    if (!i_state.in_space) begin
                        // Space after a bit mark: its length carries the bit.
                        o_state.in_space = 1'b1;
                        o_seg.duration   = data_bit ? i_cfg.one_space : i_cfg.zero_space;
                    end else begin
                        // Mark of the next bit, or the stop mark after the last.
                        o_state.in_space = 1'b0;
                        o_seg.drive      = mark_drv;
                        o_seg.duration   = i_cfg.bit_mark;
                        if (i_state.bit_index == nfs_pkg::LAST_BIT) begin
                            o_state.bit_index   = 3'd0;
                            o_state.byte_select = i_state.byte_select + 2'd1;
                            if (i_state.byte_select == nfs_pkg::SEL_CMD_INV) begin
                                o_state.phase = nfs_pkg::PH_STOP;
                            end
                        end else begin
                            o_state.bit_index = i_state.bit_index + 3'd1;
                        end
                    end
                end
                nfs_pkg::PH_STOP: begin
                    o_state.phase  = nfs_pkg::PH_GAP;
                    o_emit         = 1'b1;
                    o_seg.duration = i_cfg.frame_gap;
                end
                nfs_pkg::PH_GAP: begin
                    o_state.phase  = nfs_pkg::PH_RMARK;
                    o_emit         = 1'b1;
                    o_seg.drive    = mark_drv;
                    o_seg.duration = i_cfg.leader_mark;
                end
                nfs_pkg::PH_RMARK: begin
                    o_state.phase  = nfs_pkg::PH_RSPACE;
                    o_emit         = 1'b1;
                    o_seg.duration = nfs_pkg::REPEAT_SPACE_TICKS;
                end
                nfs_pkg::PH_RSPACE: begin
                    o_state.phase  = nfs_pkg::PH_RSTOP;
                    o_emit         = 1'b1;
                    o_seg.drive    = mark_drv;
                    o_seg.duration = i_cfg.bit_mark;
                end
                nfs_pkg::PH_RSTOP: begin
                    o_state.phase    = nfs_pkg::PH_IDLE;
                    o_emit           = 1'b1;
                    o_seg.frame_done = 1'b1;
                end
                default: begin
                    // Segment done while idle is dropped.
                    o_emit = 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/nec_ir_frame_sequencer.sv
// Output: a request that yields a segment shows it on the output in the cycle
// after it is accepted; requests that yield nothing leave no trace.
// Throughput: one request per cycle while no waiting segment is stalled, set
// by the single state update between the state and output registers.
// Reset: synchronous, active low; the sequencer returns to idle, the output
// register empties and all configuration registers take their defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_frame_sequencer
// Steps through an NEC infrared frame plus one repeat code, emitting one line
// segment (drive, duration) per start while idle or segment-done in a frame.
// ----------------------------------------------------------------------------
module nec_ir_frame_sequencer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // Configuration write port
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_index,
    input  wire [15:0] i_cfg_data,
    // Request channel
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_mode,
    input  wire [7:0]  i_command,
    // Segment channel
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [1:0] o_drive,
    output logic [15:0] o_duration,
    output logic       o_frame_done
);

    nfs_pkg::t_cfg   r_cfg;
    nfs_pkg::t_state r_state;
    nfs_pkg::t_state n_state;
    nfs_pkg::t_seg   r_seg;
    nfs_pkg::t_seg   n_seg;
    logic            n_emit;
    logic            r_out_valid;
    logic            in_acc;

    // A request is taken unless a segment is waiting and the sink stalls.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.customer_code <= nfs_pkg::RST_CUSTOMER_CODE;
            r_cfg.mark_mode     <= nfs_pkg::RST_MARK_MODE;
            r_cfg.leader_mark   <= nfs_pkg::RST_LEADER_MARK;
            r_cfg.leader_space  <= nfs_pkg::RST_LEADER_SPACE;
            r_cfg.bit_mark      <= nfs_pkg::RST_BIT_MARK;
            r_cfg.one_space     <= nfs_pkg::RST_ONE_SPACE;
            r_cfg.zero_space    <= nfs_pkg::RST_ZERO_SPACE;
            r_cfg.frame_gap     <= nfs_pkg::RST_FRAME_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nfs_pkg::CFG_CUSTOMER_CODE: r_cfg.customer_code <= i_cfg_data;
                nfs_pkg::CFG_MARK_MODE:     r_cfg.mark_mode     <= i_cfg_data[0];
                nfs_pkg::CFG_LEADER_MARK:   r_cfg.leader_mark   <= i_cfg_data;
                nfs_pkg::CFG_LEADER_SPACE:  r_cfg.leader_space  <= i_cfg_data;
                nfs_pkg::CFG_BIT_MARK:      r_cfg.bit_mark      <= i_cfg_data;
                nfs_pkg::CFG_ONE_SPACE:     r_cfg.one_space     <= i_cfg_data;
                nfs_pkg::CFG_ZERO_SPACE:    r_cfg.zero_space    <= i_cfg_data;
                nfs_pkg::CFG_FRAME_GAP:     r_cfg.frame_gap     <= i_cfg_data;
                default:                    r_cfg               <= r_cfg;
            endcase
        end
    end

    // Next state and segment for the request at the port.
    nfs_step u_step (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_mode    (i_mode),
        .i_command (i_command),
        .o_state   (n_state),
        .o_emit    (n_emit),
        .o_seg     (n_seg)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= nfs_pkg::PH_IDLE;
            r_state.bit_index    <= 3'd0;
            r_state.in_space     <= 1'b0;
            r_state.byte_select  <= nfs_pkg::SEL_ID;
            r_state.command_byte <= 8'd0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // Output register: loads whenever a request is taken that yields a segment.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= n_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_seg <= n_seg;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_drive      = r_seg.drive;
    assign o_duration   = r_seg.duration;
    assign o_frame_done = r_seg.frame_done;

    // The closing segment carries no drive and no duration.
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |->
            (o_drive == nfs_pkg::DRV_IDLE && o_duration == 16'd0))
        else $error("frame done segment carries drive or duration");

    // A start taken while idle yields the lead-in segment next cycle.
    a_start_leadin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == nfs_pkg::MODE_START && r_state.phase == nfs_pkg::PH_IDLE)
            |=> (o_out_valid && o_duration == nfs_pkg::LEAD_IN_TICKS
                 && o_drive == nfs_pkg::DRV_IDLE && !o_frame_done))
        else $error("start did not produce the lead-in segment");

    // A waiting segment that the sink stalls is held.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_seg)))
        else $error("stalled segment was lost or changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Drive code three is never produced.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive != 2'd3))
        else $error("undefined drive code");

endmodule
`default_nettype wire

>>> tb/nec_ir_segment_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nec_ir_segment_checker
// Watches the request, segment and register ports of the NEC frame sequencer.
// It keeps its own copy of the sequencer state and timing registers, works
// out the segment that each accepted request should give, and compares every
// accepted segment with the oldest one still due.
// ----------------------------------------------------------------------------
module nec_ir_segment_checker
    import nfs_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_index,
    input  wire [15:0] i_cfg_data,
    input  wire        i_in_valid,
    input  wire        i_in_stall,
    input  wire        i_mode,
    input  wire [7:0]  i_command,
    input  wire        i_out_valid,
    input  wire        i_out_stall,
    input  wire [1:0]  i_drive,
    input  wire [15:0] i_duration,
    input  wire        i_frame_done,
    output int         o_errors,
    output int         o_pending
);

    t_cfg   timing;
    t_state seq;
    t_seg   segments_due[$];
    t_seg   seen_seg;
    t_seg   due_seg;
    int     errors;

    // Byte of the 32 data bits that the given select points at.
    function automatic logic [7:0] sent_byte(input logic [1:0] sel);
        case (sel)
            SEL_ID:     return timing.customer_code[7:0];
            SEL_ID_INV: return timing.customer_code[15:8];
            SEL_CMD:    return seq.command_byte;
            default:    return seq.command_byte ^ BYTE_MASK;
        endcase
    endfunction

    // Steps the sequencer copy by one request and queues the segment it gives.
    task automatic advance_sequencer(input logic mode, input logic [7:0] cmd);
        t_seg       seg;
        logic       busy;
        logic       emits;
        logic [1:0] mark_drv;
        logic [7:0] data;
        begin
            busy     = (seq.phase >= PH_LEADIN) && (seq.phase <= PH_RSTOP);
            mark_drv = timing.mark_mode ? DRV_LOW : DRV_CARRIER;
            seg      = '0;
            emits    = 1'b1;
            if (!busy) begin
                seq.phase = PH_IDLE;
            end
            if (mode == MODE_START) begin
                // A start in the middle of a frame is dropped without a trace.
                if (busy) begin
                    emits = 1'b0;
                end else begin
                    seq.command_byte = cmd;
                    seq.bit_index    = '0;
                    seq.byte_select  = SEL_ID;
                    seq.in_space     = 1'b0;
                    seq.phase        = PH_LEADIN;
                    seg.drive        = DRV_IDLE;
                    seg.duration     = LEAD_IN_TICKS;
                end
            end else begin
                case (seq.phase)
                    PH_LEADIN: begin
                        seq.phase    = PH_LMARK;
                        seg.drive    = mark_drv;
                        seg.duration = timing.leader_mark;
                    end
                    PH_LMARK: begin
                        seq.phase    = PH_LSPACE;
                        seg.duration = timing.leader_space;
                    end
                    PH_LSPACE: begin
                        seq.phase       = PH_DATA;
                        seq.bit_index   = '0;
                        seq.byte_select = SEL_ID;
                        seq.in_space    = 1'b0;
                        seg.drive       = mark_drv;
                        seg.duration    = timing.bit_mark;
                    end
                    PH_DATA: begin
                        if (!seq.in_space) begin
                            // Space after a bit mark: its length carries the bit.
                            data         = sent_byte(seq.byte_select);
                            seq.in_space = 1'b1;
                            seg.duration = data[seq.bit_index] ? timing.one_space
                                                                : timing.zero_space;
                        end else begin
                            // Next bit mark, or the stop mark after the last bit.
                            seq.in_space = 1'b0;
                            if (seq.bit_index == LAST_BIT && seq.byte_select == SEL_CMD_INV) begin
                                seq.bit_index   = '0;
                                seq.byte_select = SEL_ID;
                                seq.phase       = PH_STOP;
                            end else if (seq.bit_index == LAST_BIT) begin
                                seq.bit_index   = '0;
                                seq.byte_select = seq.byte_select + 2'd1;
                            end else begin
                                seq.bit_index = seq.bit_index + 3'd1;
                            end
                            seg.drive    = mark_drv;
                            seg.duration = timing.bit_mark;
                        end
                    end
                    PH_STOP: begin
                        seq.phase    = PH_GAP;
                        seg.duration = timing.frame_gap;
                    end
                    PH_GAP: begin
                        seq.phase    = PH_RMARK;
                        seg.drive    = mark_drv;
                        seg.duration = timing.leader_mark;
                    end
                    PH_RMARK: begin
                        seq.phase    = PH_RSPACE;
                        seg.duration = REPEAT_SPACE_TICKS;
                    end
                    PH_RSPACE: begin
                        seq.phase    = PH_RSTOP;
                        seg.drive    = mark_drv;
                        seg.duration = timing.bit_mark;
                    end
                    PH_RSTOP: begin
                        seq.phase      = PH_IDLE;
                        seg.frame_done = 1'b1;
                    end
                    default: begin
                        emits = 1'b0;
                    end
                endcase
            end
            if (emits) begin
                segments_due.push_back(seg);
            end
        end
    endtask

    // Segments are compared before the request of the same edge is predicted,
    // since a segment is registered and so always trails its request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timing.customer_code = RST_CUSTOMER_CODE;
            timing.mark_mode     = RST_MARK_MODE;
            timing.leader_mark   = RST_LEADER_MARK;
            timing.leader_space  = RST_LEADER_SPACE;
            timing.bit_mark      = RST_BIT_MARK;
            timing.one_space     = RST_ONE_SPACE;
            timing.zero_space    = RST_ZERO_SPACE;
            timing.frame_gap     = RST_FRAME_GAP;
            seq                  = '0;
            seq.phase            = PH_IDLE;
            segments_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CUSTOMER_CODE: timing.customer_code = i_cfg_data;
                    CFG_MARK_MODE:     timing.mark_mode     = i_cfg_data[0];
                    CFG_LEADER_MARK:   timing.leader_mark   = i_cfg_data;
                    CFG_LEADER_SPACE:  timing.leader_space  = i_cfg_data;
                    CFG_BIT_MARK:      timing.bit_mark      = i_cfg_data;
                    CFG_ONE_SPACE:     timing.one_space     = i_cfg_data;
                    CFG_ZERO_SPACE:    timing.zero_space    = i_cfg_data;
                    default:           timing.frame_gap     = i_cfg_data;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                seen_seg.drive      = i_drive;
                seen_seg.duration   = i_duration;
                seen_seg.frame_done = i_frame_done;
                if (segments_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: segment with none due: drive %0d duration %0d done %0b",
                                 $realtime, seen_seg.drive, seen_seg.duration,
                                 seen_seg.frame_done);
                    end
                end else begin
                    due_seg = segments_due.pop_front();
                    if (seen_seg.drive !== due_seg.drive ||
                        seen_seg.duration !== due_seg.duration ||
                        seen_seg.frame_done !== due_seg.frame_done) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: segment mismatch: drive %0d/%0d duration %0d/%0d done %0b/%0b (expected/actual)",
                                     $realtime, due_seg.drive, seen_seg.drive,
                                     due_seg.duration, seen_seg.duration,
                                     due_seg.frame_done, seen_seg.frame_done);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_sequencer(i_mode, i_command);
            end
        end
        o_errors  <= errors;
        o_pending <= segments_due.size();
    end

endmodule

>>> tb/nec_ir_frame_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nec_ir_frame_sequencer_tb
// Drives start and segment-done requests through whole NEC frames under
// several timing settings, with random gaps on both channels and a long
// output hold-off, and leaves all checking to the segment checker.
// ----------------------------------------------------------------------------
module nec_ir_frame_sequencer_tb;
    import nfs_pkg::*;

    // Segment-done requests from a start until the frame has closed.
    localparam int SEGS_PER_FRAME = 72;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int PHASE_REQUESTS = 50;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = CFG_CUSTOMER_CODE;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        mode      = MODE_START;
    logic [7:0]  command   = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  drive;
    logic [15:0] duration;
    logic        frame_done;

    logic        calm      = 1'b0;
    int          hold_asks = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          frame_left;
    int          frames;
    int          requests;
    int          idle_cycles;
    int          errors;
    int          pending;

    nec_ir_frame_sequencer dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_mode       (mode),
        .i_command    (command),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_drive      (drive),
        .o_duration   (duration),
        .o_frame_done (frame_done)
    );

    nec_ir_segment_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_mode       (mode),
        .i_command    (command),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_drive      (drive),
        .i_duration   (duration),
        .i_frame_done (frame_done),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Segment receiver: random stalls, or a counted hold-off when one is asked.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 38);
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offers one request, after a random gap, and waits until it is taken.
    task automatic send_req(input logic m, input logic [7:0] c);
        begin
            while (!calm && $urandom_range(99) < 38) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            mode     <= m;
            command  <= c;
            @(posedge clk);
            while (in_stall) begin
                @(posedge clk);
            end
            requests++;
            if (m == MODE_START && frame_left == 0) begin
                frame_left = SEGS_PER_FRAME;
                frames++;
            end else if (m == MODE_SEG_DONE && frame_left != 0) begin
                frame_left--;
            end
        end
    endtask

    // Stops offering and waits until every due segment has come out.
    task automatic drain;
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0) begin
                @(posedge clk);
            end
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
        end
    endtask

    task automatic set_timing(input logic [15:0] cust, input logic mm,
                              input logic [15:0] lm, input logic [15:0] ls,
                              input logic [15:0] bm, input logic [15:0] os,
                              input logic [15:0] zs, input logic [15:0] fg);
        begin
            write_reg(CFG_CUSTOMER_CODE, cust);
            write_reg(CFG_MARK_MODE, {15'd0, mm});
            write_reg(CFG_LEADER_MARK, lm);
            write_reg(CFG_LEADER_SPACE, ls);
            write_reg(CFG_BIT_MARK, bm);
            write_reg(CFG_ONE_SPACE, os);
            write_reg(CFG_ZERO_SPACE, zs);
            write_reg(CFG_FRAME_GAP, fg);
            cfg_we <= 1'b0;
        end
    endtask

    // Mostly whole frames with random commands; now and then a stray start
    // inside a frame or a stray segment-done between frames.
    task automatic run_frames(input int quota);
        int         useful;
        logic [7:0] c;
        begin
            useful = 0;
            while (useful < quota || frame_left != 0) begin
                c = 8'($urandom_range(255));
                if (frame_left == 0) begin
                    if ($urandom_range(99) < 8) begin
                        send_req(MODE_SEG_DONE, c);
                    end else begin
                        send_req(MODE_START, c);
                        useful++;
                    end
                end else if ($urandom_range(99) < 6) begin
                    send_req(MODE_START, c);
                end else begin
                    send_req(MODE_SEG_DONE, c);
                    useful++;
                end
            end
        end
    endtask

    initial begin
        int p;
        frame_left = 0;
        frames     = 0;
        requests   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at reset timing: stray segment-done, start with an
        // all-zero command, starts while busy, then the leader and early bits.
        send_req(MODE_SEG_DONE, 8'hA5);
        send_req(MODE_START, 8'h00);
        send_req(MODE_START, 8'hFF);
        repeat (18) send_req(MODE_SEG_DONE, 8'h00);
        send_req(MODE_START, 8'h3C);

        for (p = 0; p < 7; p++) begin
            if (p != 0) begin
                drain();
                calm <= (p == 1);
                case (p)
                    1: set_timing(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF, 16'hFFFF);
                    2: set_timing(16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                                  16'h0000, 16'h0000, 16'h0000);
                    default: set_timing(16'($urandom), 1'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom));
                endcase
                // Output held off while requests keep coming, so the block backs up.
                if (p == 1) begin
                    hold_asks <= hold_asks + 1;
                end
            end
            run_frames(PHASE_REQUESTS);
        end
        drain();
        repeat (20) @(posedge clk);

        $display("Run covered %0d requests in %0d frames over 7 timing settings,", requests,
                 frames);
        $display("including all-zero and all-ones timings, both mark modes and a long hold-off.");
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> nec_ir_frame_sequencer.f
design/nfs_pkg.sv
design/nfs_step.sv
design/nec_ir_frame_sequencer.sv
tb/nec_ir_segment_checker.sv
tb/nec_ir_frame_sequencer_tb.sv
